// ----- hdl/pab_pkg.sv -----
package pab_pkg;

   // Color lanes: red, green, blue
   localparam int LANES = 3;

   // Byte address width of the CSR port (5 registers at 4*i)
   localparam int CSR_AW = 5;

   // blend_mode codes
   localparam logic [2:0] MODE_COPY     = 3'd0;
   localparam logic [2:0] MODE_SPRITE   = 3'd1;
   localparam logic [2:0] MODE_PREMUL   = 3'd2;
   localparam logic [2:0] MODE_STRAIGHT = 3'd3;
   localparam logic [2:0] MODE_MASKED   = 3'd4;
   localparam logic [2:0] MODE_PMSRC    = 3'd5;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_MODE       = 3'd0;
   localparam logic [2:0] REG_MASK_RED   = 3'd1;
   localparam logic [2:0] REG_MASK_GREEN = 3'd2;
   localparam logic [2:0] REG_MASK_BLUE  = 3'd3;
   localparam logic [2:0] REG_MASK_ALPHA = 3'd4;

   // reset values
   localparam logic [2:0] MODE_RESET = MODE_STRAIGHT;
   localparam logic [7:0] MASK_RESET = 8'hFF;

   typedef struct packed {
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       changed;
   } rsp_word_type;

   // per-word control carried alongside the lanes
   typedef struct packed {
      logic [2:0] mode;
      logic       a_zero;
      logic       a_full;
   } ctrl_type;

endpackage

// ----- hdl/pixel_alpha_blend_unit.sv -----
// Pixel alpha blend unit: composites one source RGB pixel with alpha over one
// destination RGB pixel per word. Three color lanes run side by side, each a
// two-stage multiply pipeline (mask scale, then destination/source weighting),
// and a merge stage packs the channels and the changed flag into the output
// register. Throughput is one word per clock unless the output stalls; an
// accepted req passes the stage 1, stage 2 and output registers to rsp_valid.
// The whole pipeline holds only when the output register is full and rsp_stall
// is high, so req_stall is exactly that condition. blend_mode and the mask
// registers are read live and must only be written while no word is in flight.
module pixel_alpha_blend_unit
   import pab_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // input words
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_data,
   // result words
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_data,
   // APB register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // config registers
   logic [2:0] blend_mode_ff;
   logic [7:0] mask_red_ff, mask_green_ff, mask_blue_ff, mask_alpha_ff;
   logic [2:0] reg_index;
   logic       csr_wr;

   // pipeline control
   logic       advance;
   logic       valid_s1_ff, valid_s2_ff;
   ctrl_type   ctrl_in, ctrl_s1_ff, ctrl_s2_ff;

   // shared alpha path
   logic [15:0] alpha_prod;
   logic [7:0]  alpha_in, alpha_s1_ff;

   // lane wiring
   logic [7:0] dst_ch  [LANES];
   logic [7:0] src_ch  [LANES];
   logic [7:0] mask_ch [LANES];
   logic [7:0] res_ch  [LANES];

   // ---------------- register port ----------------
   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_AW-1:2];
   assign csr_wr    = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= MODE_RESET;
         mask_red_ff   <= MASK_RESET;
         mask_green_ff <= MASK_RESET;
         mask_blue_ff  <= MASK_RESET;
         mask_alpha_ff <= MASK_RESET;
      end else if (csr_wr) begin
         case (reg_index)
            REG_MODE:       blend_mode_ff <= pwdata[2:0];
            REG_MASK_RED:   mask_red_ff   <= pwdata[7:0];
            REG_MASK_GREEN: mask_green_ff <= pwdata[7:0];
            REG_MASK_BLUE:  mask_blue_ff  <= pwdata[7:0];
            REG_MASK_ALPHA: mask_alpha_ff <= pwdata[7:0];
            default: ;  // unmapped: write dropped
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MODE:       prdata = {29'd0, blend_mode_ff};
         REG_MASK_RED:   prdata = {24'd0, mask_red_ff};
         REG_MASK_GREEN: prdata = {24'd0, mask_green_ff};
         REG_MASK_BLUE:  prdata = {24'd0, mask_blue_ff};
         REG_MASK_ALPHA: prdata = {24'd0, mask_alpha_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // every stage moves together unless the output word is stuck
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
      end else if (advance) begin
         valid_s1_ff <= req_valid;
         valid_s2_ff <= valid_s1_ff;
      end
   end

   assign ctrl_in = '{mode:   blend_mode_ff,
                      a_zero: (req_data.src_alpha == 8'h00),
                      a_full: (req_data.src_alpha == 8'hFF)};

   // masked mode scales alpha before the lanes use it
   assign alpha_prod = {8'd0, req_data.src_alpha} * {8'd0, mask_alpha_ff};
   assign alpha_in   = (blend_mode_ff == MODE_MASKED) ? alpha_prod[15:8]
                                                       : req_data.src_alpha;

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_s1_ff  <= ctrl_in;
         ctrl_s2_ff  <= ctrl_s1_ff;
         alpha_s1_ff <= alpha_in;
      end
   end

   // ---------------- color lanes ----------------
   assign dst_ch[0]  = req_data.dst_red;
   assign dst_ch[1]  = req_data.dst_green;
   assign dst_ch[2]  = req_data.dst_blue;
   assign src_ch[0]  = req_data.src_red;
   assign src_ch[1]  = req_data.src_green;
   assign src_ch[2]  = req_data.src_blue;
   assign mask_ch[0] = mask_red_ff;
   assign mask_ch[1] = mask_green_ff;
   assign mask_ch[2] = mask_blue_ff;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      pab_lane u_lane (
         .clock    (clock),
         .advance  (advance),
         .ctrl_s0  (ctrl_in),
         .ctrl_s2  (ctrl_s2_ff),
         .dst      (dst_ch[i]),
         .src      (src_ch[i]),
         .mask     (mask_ch[i]),
         .alpha_s1 (alpha_s1_ff),
         .result   (res_ch[i])
      );
   end

   // ---------------- merge / output register ----------------
   pab_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_s2  (valid_s2_ff),
      .ctrl_s2   (ctrl_s2_ff),
      .red       (res_ch[0]),
      .green     (res_ch[1]),
      .blue      (res_ch[2]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/pab_lane.sv -----
module pab_lane
   import pab_pkg::*;
(
   input  logic       clock,
   input  logic       advance,
   input  ctrl_type   ctrl_s0,
   input  ctrl_type   ctrl_s2,
   input  logic [7:0] dst,
   input  logic [7:0] src,
   input  logic [7:0] mask,
   input  logic [7:0] alpha_s1,
   output logic [7:0] result
);

   logic [15:0] smask_prod;
   logic [7:0]  seff_in;
   logic [7:0]  dst_s1_ff, src_s1_ff, seff_s1_ff;
   logic [8:0]  inv_alpha;
   logic [16:0] pd_in;
   logic [15:0] ps_in;
   logic [7:0]  dst_s2_ff, src_s2_ff;
   logic [16:0] pd_s2_ff;
   logic [15:0] ps_s2_ff;
   logic [16:0] mix_sum;
   logic [8:0]  pm_sum;
   logic [7:0]  mix_val, pm_val;

   // stage 1: mask scaling of the source channel
   assign smask_prod = {8'd0, src} * {8'd0, mask};
   assign seff_in    = (ctrl_s0.mode == MODE_MASKED) ? smask_prod[15:8] : src;

   always_ff @(posedge clock) begin
      if (advance) begin
         dst_s1_ff  <= dst;
         src_s1_ff  <= src;
         seff_s1_ff <= seff_in;
      end
   end

   // stage 2: destination and source weighting
   assign inv_alpha = 9'd256 - {1'b0, alpha_s1};
   assign pd_in     = {9'd0, dst_s1_ff} * {8'd0, inv_alpha};
   assign ps_in     = {8'd0, seff_s1_ff} * {8'd0, alpha_s1};

   always_ff @(posedge clock) begin
      if (advance) begin
         dst_s2_ff <= dst_s1_ff;
         src_s2_ff <= src_s1_ff;
         pd_s2_ff  <= pd_in;
         ps_s2_ff  <= ps_in;
      end
   end

   // result select
   assign mix_sum = pd_s2_ff + {1'b0, ps_s2_ff};
   assign mix_val = mix_sum[15:8];
   assign pm_sum  = {1'b0, pd_s2_ff[15:8]} + {1'b0, src_s2_ff};
   assign pm_val  = pm_sum[8] ? 8'hFF : pm_sum[7:0];

   always_comb begin
      case (ctrl_s2.mode)
         MODE_COPY: begin
            result = src_s2_ff;
         end
         MODE_SPRITE: begin
            result = ctrl_s2.a_zero ? dst_s2_ff : src_s2_ff;
         end
         MODE_PREMUL: begin
            result = pm_val;
         end
         MODE_STRAIGHT: begin
            if (ctrl_s2.a_full) begin
               result = src_s2_ff;
            end else if (ctrl_s2.a_zero) begin
               result = dst_s2_ff;
            end else begin
               result = mix_val;
            end
         end
         MODE_MASKED: begin
            result = mix_val;
         end
         MODE_PMSRC: begin
            result = ps_s2_ff[15:8];
         end
         default: begin
            result = dst_s2_ff;
         end
      endcase
   end

endmodule

// ----- hdl/pab_merge.sv -----
module pab_merge
   import pab_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         valid_s2,
   input  ctrl_type     ctrl_s2,
   input  logic [7:0]   red,
   input  logic [7:0]   green,
   input  logic [7:0]   blue,
   output logic         rsp_valid,
   output rsp_word_type rsp_data
);

   logic         valid_ff;
   rsp_word_type data_ff, data_in;
   logic         changed_in;

   // no write for transparent sprite/straight pixels or unused modes
   always_comb begin
      case (ctrl_s2.mode)
         MODE_SPRITE, MODE_STRAIGHT: changed_in = !ctrl_s2.a_zero;
         MODE_COPY, MODE_PREMUL, MODE_MASKED, MODE_PMSRC: changed_in = 1'b1;
         default: changed_in = 1'b0;
      endcase
   end

   assign data_in = '{out_red: red, out_green: green, out_blue: blue, changed: changed_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_s2;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hdl/pab_checker.sv -----
module pab_checker
   import pab_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // a held result word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a held result word does not change
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // input is held off only by a stuck output word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without output backpressure");

   // an accepted word reaches the output through the stage 1, stage 2 and output registers when not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted word did not arrive at output");

endmodule

bind pixel_alpha_blend_unit pab_checker u_pab_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
